// ----- sv/srbr_pkg.sv -----
// srbr_pkg: shared types and constants for the spike rate bias regulator.
// Holds the payload structs, the controller/datapath command and status structs, and codes.
// No dependencies.
`timescale 1ns / 1ps

package srbr_pkg;

    // Core index: 2 bits of chip, 2 bits of core (up to a 2x2 grid of chips, 2x2 cores each)
    localparam int CORE_SEL_W    = 4;
    localparam int CORES_PER_CHIP = 4;

    localparam int WINDOW_W      = 24;
    localparam int TARGET_W      = 25;
    localparam int CFG_DATA_W    = 25;
    localparam int CFG_INDEX_W   = 2;
    localparam int OUT_COUNT_W   = 25;
    localparam int COARSE_W      = 3;
    localparam int FINE_W        = 8;
    localparam int STATUS_W      = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_TICKS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADJUST_ENABLE = 2'd2;

    localparam logic [WINDOW_W-1:0] WINDOW_TICKS_RST  = 24'd3000;
    localparam logic [TARGET_W-1:0] TARGET_COUNT_RST  = 25'd76800;

    // Input function codes
    localparam logic FUNC_SPIKE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Adjust status codes
    localparam logic [STATUS_W-1:0] ADJ_NONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ADJ_RAISED    = 3'd1;
    localparam logic [STATUS_W-1:0] ADJ_LOWERED   = 3'd2;
    localparam logic [STATUS_W-1:0] ADJ_MAX_LIMIT = 3'd3;
    localparam logic [STATUS_W-1:0] ADJ_MIN_LIMIT = 3'd4;

    localparam logic [COARSE_W-1:0] COARSE_STRONGEST = 3'd0;
    localparam logic [COARSE_W-1:0] COARSE_WEAKEST   = 3'd7;
    localparam logic [FINE_W-1:0]   FINE_RST         = 8'd0;
    localparam logic [FINE_W:0]     FINE_LIMIT       = 9'd255;

    typedef struct packed {
        logic       func;
        logic [5:0] x_coord;
        logic [5:0] y_coord;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             chip_id;
        logic [1:0]             core_id;
        logic [OUT_COUNT_W-1:0] core_count;
        logic [COARSE_W-1:0]    coarse_bias;
        logic [FINE_W-1:0]      fine_bias;
        logic                   bias_changed;
        logic [STATUS_W-1:0]    adjust_status;
        logic                   last_core;
    } out_item_t;

    typedef struct packed {
        logic                  spike_inc;
        logic                  tick;
        logic                  emit;
        logic [CORE_SEL_W-1:0] sweep_idx;
        logic                  last;
    } ctl_cmd_t;

    typedef struct packed {
        logic window_close;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/spike_rate_bias_regulator.sv -----
// Spike rate bias regulator, top level: per-core spike counting and bias stepping.
// Throughput: one spike or tick beat per cycle. A tick that closes the window stalls the
// input while the sweep emits NUM_CHIPS*4 result beats, one per cycle when out_stall is low;
// after that tick the sweep state is entered, and each result is registered in the output register.
// Reset (rst_n, async low): counters zero, coarse 7, fine 0, timer zero, config defaults.
`timescale 1ns / 1ps

module spike_rate_bias_regulator #(
    parameter int NUM_CHIPS   = 4,
    parameter int CORE_COLS   = 16,
    parameter int CORE_ROWS   = 16,
    parameter int FINE_STEP   = 15,
    parameter int COUNT_WIDTH = 25
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  srbr_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output srbr_pkg::out_item_t              out_data,
    input  logic                             cfg_we,
    input  logic [srbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srbr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    srbr_pkg::ctl_cmd_t   cmd;
    srbr_pkg::dp_status_t status;

    srbr_ctrl #(
        .NUM_CHIPS (NUM_CHIPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_data.func),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    srbr_datapath #(
        .NUM_CHIPS   (NUM_CHIPS),
        .CORE_COLS   (CORE_COLS),
        .CORE_ROWS   (CORE_ROWS),
        .FINE_STEP   (FINE_STEP),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ----- sv/srbr_ctrl.sv -----
// srbr_ctrl: controller for the spike rate bias regulator.
// Accepts beats, walks the core sweep at window end. Uses srbr_pkg.
`timescale 1ns / 1ps

module srbr_ctrl #(
    parameter int NUM_CHIPS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_func,
    output logic                 in_stall,
    input  srbr_pkg::dp_status_t status,
    output srbr_pkg::ctl_cmd_t   cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    localparam logic [srbr_pkg::CORE_SEL_W-1:0] LAST_IDX =
        srbr_pkg::CORE_SEL_W'(NUM_CHIPS * srbr_pkg::CORES_PER_CHIP - 1);

    logic                            state_reg, state_next;
    logic [srbr_pkg::CORE_SEL_W-1:0] idx_reg, idx_next;
    logic                            accept;

    assign in_stall = (state_reg == ST_SWEEP);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd.spike_inc = accept && (in_func == srbr_pkg::FUNC_SPIKE);
        cmd.tick      = accept && (in_func == srbr_pkg::FUNC_TICK);
        cmd.emit      = (state_reg == ST_SWEEP) && status.out_free;
        cmd.sweep_idx = idx_reg;
        cmd.last      = (idx_reg == LAST_IDX);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.tick && status.window_close)
                begin
                    state_next = ST_SWEEP;
                    idx_next   = '0;
                end
            end
            ST_SWEEP:
            begin
                if (cmd.emit)
                begin
                    if (cmd.last)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- sv/srbr_datapath.sv -----
// srbr_datapath: counters, bias store, window timer, config and output register.
// Driven by srbr_ctrl commands. Uses srbr_pkg.
`timescale 1ns / 1ps

module srbr_datapath #(
    parameter int NUM_CHIPS   = 4,
    parameter int CORE_COLS   = 16,
    parameter int CORE_ROWS   = 16,
    parameter int FINE_STEP   = 15,
    parameter int COUNT_WIDTH = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srbr_pkg::in_item_t                  in_data,
    input  logic                                cfg_we,
    input  logic [srbr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [srbr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  srbr_pkg::ctl_cmd_t                  cmd,
    output srbr_pkg::dp_status_t                status,
    input  logic                                out_stall,
    output logic                                out_valid,
    output srbr_pkg::out_item_t                 out_data
);

    localparam int NUM_CORES = NUM_CHIPS * srbr_pkg::CORES_PER_CHIP;
    localparam int IDX_W     = $clog2(NUM_CORES);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [srbr_pkg::FINE_W-1:0] FINE_INC = srbr_pkg::FINE_W'(FINE_STEP);

    // config registers
    logic [srbr_pkg::WINDOW_W-1:0] window_reg;
    logic [srbr_pkg::TARGET_W-1:0] target_reg;
    logic                          adj_en_reg;

    logic [srbr_pkg::WINDOW_W-1:0] elapsed_reg, elapsed_next;
    logic [srbr_pkg::WINDOW_W-1:0] elapsed_inc, limit;

    logic [COUNT_WIDTH-1:0]        count_reg  [NUM_CORES];
    logic [srbr_pkg::COARSE_W-1:0] coarse_reg [NUM_CORES];
    logic [srbr_pkg::FINE_W-1:0]   fine_reg   [NUM_CORES];

    logic                 out_valid_reg;
    srbr_pkg::out_item_t  out_data_reg;

    // coordinate decode tables: bit k gives the selected digit for coordinate k
    logic [63:0] ccol_map, hcol_map, crow_map, hrow_map;

    for (genvar k = 0; k < 64; k++)
    begin : g_map
        assign ccol_map[k] = (((k / CORE_COLS) % 2) != 0);
        assign hcol_map[k] = (((k / (2 * CORE_COLS)) % 2) != 0);
        assign crow_map[k] = (((k / CORE_ROWS) % 2) != 0);
        assign hrow_map[k] = (((k / (2 * CORE_ROWS)) % 2) != 0);
    end

    logic [1:0]                      spk_chip;
    logic [srbr_pkg::CORE_SEL_W-1:0] spk_idx;
    logic                            spk_ok;
    logic [NUM_CORES-1:0]            hit;

    assign spk_chip = {hrow_map[in_data.y_coord], hcol_map[in_data.x_coord]};
    assign spk_idx  = {spk_chip, crow_map[in_data.y_coord], ccol_map[in_data.x_coord]};
    assign spk_ok   = cmd.spike_inc && (32'(spk_chip) < 32'(NUM_CHIPS));

    for (genvar i = 0; i < NUM_CORES; i++)
    begin : g_hit
        assign hit[i] = spk_ok && (spk_idx == srbr_pkg::CORE_SEL_W'(i));
    end

    // window timer; a zero window acts as one tick
    assign limit        = (window_reg == '0) ? srbr_pkg::WINDOW_W'(1) : window_reg;
    assign elapsed_inc  = elapsed_reg + 1'b1;
    assign status.window_close = !((elapsed_inc < limit) && (elapsed_inc != '0));
    assign status.out_free     = !out_valid_reg || !out_stall;

    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (cmd.tick)
            elapsed_next = status.window_close ? '0 : elapsed_inc;
    end

    // bias rule for the core under the sweep
    logic [IDX_W-1:0]              sel;
    logic [COUNT_WIDTH-1:0]        cur_count;
    logic [srbr_pkg::COARSE_W-1:0] cur_coarse, new_coarse;
    logic [srbr_pkg::FINE_W-1:0]   cur_fine, new_fine;
    logic [srbr_pkg::FINE_W:0]     fine_sum;
    logic                          changed;
    logic [srbr_pkg::STATUS_W-1:0] adj_status;
    logic                          below, above;

    assign sel        = cmd.sweep_idx[IDX_W-1:0];
    assign cur_count  = count_reg[sel];
    assign cur_coarse = coarse_reg[sel];
    assign cur_fine   = fine_reg[sel];
    assign fine_sum   = {1'b0, cur_fine} + {1'b0, FINE_INC};
    assign below      = 32'(cur_count) < 32'(target_reg);
    assign above      = 32'(cur_count) > 32'(target_reg);

    always_comb
    begin
        new_coarse = cur_coarse;
        new_fine   = cur_fine;
        changed    = 1'b0;
        adj_status = srbr_pkg::ADJ_NONE;
        if (adj_en_reg)
        begin
            priority if (below)
            begin
                priority if (fine_sum <= srbr_pkg::FINE_LIMIT)
                begin
                    new_fine   = fine_sum[srbr_pkg::FINE_W-1:0];
                    changed    = 1'b1;
                    adj_status = srbr_pkg::ADJ_RAISED;
                end
                else if (cur_coarse != srbr_pkg::COARSE_STRONGEST)
                begin
                    new_fine   = FINE_INC;
                    new_coarse = cur_coarse - 1'b1;
                    changed    = 1'b1;
                    adj_status = srbr_pkg::ADJ_RAISED;
                end
                else
                begin
                    adj_status = srbr_pkg::ADJ_MAX_LIMIT;
                end
            end
            else if (above)
            begin
                priority if (cur_fine >= FINE_INC)
                begin
                    new_fine   = cur_fine - FINE_INC;
                    changed    = 1'b1;
                    adj_status = srbr_pkg::ADJ_LOWERED;
                end
                else if (cur_coarse != srbr_pkg::COARSE_WEAKEST)
                begin
                    new_fine   = FINE_INC;
                    new_coarse = cur_coarse + 1'b1;
                    changed    = 1'b1;
                    adj_status = srbr_pkg::ADJ_LOWERED;
                end
                else
                begin
                    adj_status = srbr_pkg::ADJ_MIN_LIMIT;
                end
            end
            else
            begin
                adj_status = srbr_pkg::ADJ_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= srbr_pkg::WINDOW_TICKS_RST;
            target_reg <= srbr_pkg::TARGET_COUNT_RST;
            adj_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srbr_pkg::CFG_WINDOW_TICKS:  window_reg <= cfg_data[srbr_pkg::WINDOW_W-1:0];
                srbr_pkg::CFG_TARGET_COUNT:  target_reg <= cfg_data[srbr_pkg::TARGET_W-1:0];
                srbr_pkg::CFG_ADJUST_ENABLE: adj_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            elapsed_reg <= '0;
        else
            elapsed_reg <= elapsed_next;
    end

    // per-core counters and bias store; sweep clears/updates one entry per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CORES; i++)
            begin
                count_reg[i]  <= '0;
                coarse_reg[i] <= srbr_pkg::COARSE_WEAKEST;
                fine_reg[i]   <= srbr_pkg::FINE_RST;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CORES; i++)
            begin
                if (cmd.emit && (sel == IDX_W'(i)))
                begin
                    count_reg[i]  <= '0;
                    coarse_reg[i] <= new_coarse;
                    fine_reg[i]   <= new_fine;
                end
                else if (hit[i] && (count_reg[i] != COUNT_MAX))
                begin
                    count_reg[i] <= count_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.chip_id       <= cmd.sweep_idx[3:2];
            out_data_reg.core_id       <= cmd.sweep_idx[1:0];
            out_data_reg.core_count    <= srbr_pkg::OUT_COUNT_W'(cur_count);
            out_data_reg.coarse_bias   <= new_coarse;
            out_data_reg.fine_bias     <= new_fine;
            out_data_reg.bias_changed  <= changed;
            out_data_reg.adjust_status <= adj_status;
            out_data_reg.last_core     <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- verif/tb_spike_rate_bias_regulator.sv -----
// Self-checking testbench for spike_rate_bias_regulator: spike/tick beats in, per-core reports out.
// Depends on srbr_pkg (payload structs, register indexes, codes) and the top-level RTL.
`timescale 1ns / 1ps

module tb_spike_rate_bias_regulator;

    localparam int FINE_STEP     = 15;
    localparam int COUNT_WIDTH   = 25;
    localparam int NUM_CORES     = 16;
    localparam int ITEM_GOAL     = 470;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 5000;

    localparam logic [srbr_pkg::CFG_DATA_W-1:0] WINDOW_MAX = 25'h0FFFFFF;
    localparam logic [srbr_pkg::CFG_DATA_W-1:0] TARGET_MAX = 25'h1FFFFFF;
    localparam logic [COUNT_WIDTH-1:0]          COUNT_SAT  = '1;

    logic                                 clk;
    logic                                 rst_n     = 1'b0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_stall;
    srbr_pkg::in_item_t                   in_data   = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    srbr_pkg::out_item_t                  out_data;
    logic                                 cfg_we    = 1'b0;
    logic [srbr_pkg::CFG_INDEX_W-1:0]     cfg_index = srbr_pkg::CFG_WINDOW_TICKS;
    logic [srbr_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

    spike_rate_bias_regulator #(
        .NUM_CHIPS   (4),
        .CORE_COLS   (16),
        .CORE_ROWS   (16),
        .FINE_STEP   (FINE_STEP),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Shadow of the block: registers, counters, biases, tick timer
    logic [srbr_pkg::WINDOW_W-1:0] win_ticks  = srbr_pkg::WINDOW_TICKS_RST;
    logic [srbr_pkg::TARGET_W-1:0] target_cnt = srbr_pkg::TARGET_COUNT_RST;
    logic                          adjust_on  = 1'b0;
    logic [COUNT_WIDTH-1:0]        spike_cnt [NUM_CORES];
    logic [srbr_pkg::COARSE_W-1:0] coarse_m  [NUM_CORES];
    logic [srbr_pkg::FINE_W-1:0]   fine_m    [NUM_CORES];
    logic [srbr_pkg::WINDOW_W-1:0] ticks_seen = '0;

    srbr_pkg::in_item_t  pending_beats  [$];
    srbr_pkg::out_item_t core_reports_q [$];
    int        beats_queued = 0;
    int        beats_taken  = 0;
    int        errors       = 0;
    int        quiet_cycles = 0;
    int        in_gap       = 0;
    int        in_burst     = 0;
    int        stall_left   = 0;
    int        out_burst    = 0;

    // Mostly zero, some short, a few long; now and then a run with no idling at all
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst != 0)
        begin
            burst = burst - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic srbr_pkg::in_item_t spike_beat(logic [5:0] x, logic [5:0] y);
        srbr_pkg::in_item_t b;
        b.func    = srbr_pkg::FUNC_SPIKE;
        b.x_coord = x;
        b.y_coord = y;
        return b;
    endfunction

    // Spike landing on a given core index {chip row, chip col, core row, core col}
    function automatic srbr_pkg::in_item_t core_spike(logic [3:0] idx);
        return spike_beat({idx[2], idx[0], 4'($urandom_range(0, 15))},
                          {idx[3], idx[1], 4'($urandom_range(0, 15))});
    endfunction

    function automatic srbr_pkg::in_item_t tick_beat();
        srbr_pkg::in_item_t b;
        b.func    = srbr_pkg::FUNC_TICK;
        b.x_coord = 6'($urandom_range(0, 63));
        b.y_coord = 6'($urandom_range(0, 63));
        return b;
    endfunction

    function automatic bit same_report(srbr_pkg::out_item_t a, srbr_pkg::out_item_t b);
        return a.chip_id === b.chip_id && a.core_id === b.core_id
            && a.core_count === b.core_count && a.coarse_bias === b.coarse_bias
            && a.fine_bias === b.fine_bias && a.bias_changed === b.bias_changed
            && a.adjust_status === b.adjust_status && a.last_core === b.last_core;
    endfunction

    task automatic push_beat(input srbr_pkg::in_item_t b);
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic report_mismatch(input string what, input srbr_pkg::out_item_t want,
                                   input srbr_pkg::out_item_t got);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t %s", $realtime, what);
            $display("  exp chip=%0d core=%0d cnt=%0d coarse=%0d fine=%0d chg=%0d st=%0d last=%0d",
                     want.chip_id, want.core_id, want.core_count, want.coarse_bias,
                     want.fine_bias, want.bias_changed, want.adjust_status, want.last_core);
            $display("  got chip=%0d core=%0d cnt=%0d coarse=%0d fine=%0d chg=%0d st=%0d last=%0d",
                     got.chip_id, got.core_id, got.core_count, got.coarse_bias,
                     got.fine_bias, got.bias_changed, got.adjust_status, got.last_core);
        end
    endtask

    // Applies one accepted beat to the shadow state; a closing tick queues 16 core reports
    task automatic regulate_beat(input srbr_pkg::in_item_t b);
        logic [3:0]                    idx;
        logic [srbr_pkg::WINDOW_W-1:0] limit;
        logic [srbr_pkg::COARSE_W-1:0] c;
        srbr_pkg::out_item_t           r;
        int                            f;
        if (b.func == srbr_pkg::FUNC_SPIKE)
        begin
            idx = {b.y_coord[5], b.x_coord[5], b.y_coord[4], b.x_coord[4]};
            if (spike_cnt[idx] != COUNT_SAT)
                spike_cnt[idx] = spike_cnt[idx] + 1'b1;
            return;
        end
        limit      = (win_ticks == '0) ? srbr_pkg::WINDOW_W'(1) : win_ticks;
        ticks_seen = ticks_seen + 1'b1;
        if (ticks_seen < limit && ticks_seen != '0)
            return;
        ticks_seen = '0;
        for (int i = 0; i < NUM_CORES; i++)
        begin
            idx = 4'(i);
            f   = int'(fine_m[idx]);
            c   = coarse_m[idx];
            r   = '0;
            r.adjust_status = srbr_pkg::ADJ_NONE;
            if (adjust_on)
            begin
                if (spike_cnt[idx] < target_cnt)
                begin
                    if (f + FINE_STEP <= int'(srbr_pkg::FINE_LIMIT))
                    begin
                        f = f + FINE_STEP;
                        r.bias_changed  = 1'b1;
                        r.adjust_status = srbr_pkg::ADJ_RAISED;
                    end
                    else if (c != srbr_pkg::COARSE_STRONGEST)
                    begin
                        f = FINE_STEP;
                        c = c - 1'b1;
                        r.bias_changed  = 1'b1;
                        r.adjust_status = srbr_pkg::ADJ_RAISED;
                    end
                    else
                        r.adjust_status = srbr_pkg::ADJ_MAX_LIMIT;
                end
                else if (spike_cnt[idx] > target_cnt)
                begin
                    if (f >= FINE_STEP)
                    begin
                        f = f - FINE_STEP;
                        r.bias_changed  = 1'b1;
                        r.adjust_status = srbr_pkg::ADJ_LOWERED;
                    end
                    else if (c != srbr_pkg::COARSE_WEAKEST)
                    begin
                        f = FINE_STEP;
                        c = c + 1'b1;
                        r.bias_changed  = 1'b1;
                        r.adjust_status = srbr_pkg::ADJ_LOWERED;
                    end
                    else
                        r.adjust_status = srbr_pkg::ADJ_MIN_LIMIT;
                end
                fine_m[idx]   = f[srbr_pkg::FINE_W-1:0];
                coarse_m[idx] = c;
            end
            r.chip_id     = idx[3:2];
            r.core_id     = idx[1:0];
            r.core_count  = spike_cnt[idx];
            r.coarse_bias = coarse_m[idx];
            r.fine_bias   = fine_m[idx];
            r.last_core   = (idx == 4'hF);
            core_reports_q.push_back(r);
            spike_cnt[idx] = '0;
        end
    endtask

    // Input driver: holds a stalled beat, otherwise loads the next one after a random gap
    always @(posedge clk or negedge rst_n)
    begin : beat_driver
        bit load_next;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            load_next = 1'b1;
            if (in_valid)
            begin
                if (!in_stall)
                begin
                    beats_taken++;
                    regulate_beat(in_data);
                end
                else
                    load_next = 1'b0;
            end
            if (load_next)
            begin
                if (in_gap != 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_beats.pop_front();
                    in_gap = pick_gap(in_burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random stall on the receiving side
    always @(posedge clk or negedge rst_n)
    begin : report_monitor
        srbr_pkg::out_item_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (core_reports_q.size() == 0)
                    report_mismatch("unexpected result beat", '0, out_data);
                else
                begin
                    want = core_reports_q.pop_front();
                    if (!same_report(want, out_data))
                        report_mismatch("result mismatch", want, out_data);
                end
            end
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap(out_burst);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t watchdog: no beat for %0d cycles, %0d results due",
                     $realtime, QUIET_LIMIT, core_reports_q.size());
            $display("** spike_rate_bias_regulator: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Everything sent has been taken and every report has come back; spikes may still be in flight
    task automatic wait_idle();
        while (beats_taken != beats_queued || core_reports_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [srbr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [srbr_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            srbr_pkg::CFG_WINDOW_TICKS:  win_ticks  = val[srbr_pkg::WINDOW_W-1:0];
            srbr_pkg::CFG_TARGET_COUNT:  target_cnt = val[srbr_pkg::TARGET_W-1:0];
            srbr_pkg::CFG_ADJUST_ENABLE: adjust_on  = val[0];
            default: ;
        endcase
    endtask

    initial
    begin : stimulus
        logic [3:0] hot;
        int         pick;
        int         n;
        for (int i = 0; i < NUM_CORES; i++)
        begin
            spike_cnt[i] = '0;
            coarse_m[i]  = srbr_pkg::COARSE_WEAKEST;
            fine_m[i]    = srbr_pkg::FINE_RST;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: corner neurons of every chip, then a tick that does not close
        push_beat(spike_beat(6'd0, 6'd0));
        push_beat(spike_beat(6'd63, 6'd63));
        push_beat(spike_beat(6'd16, 6'd0));
        push_beat(spike_beat(6'd0, 6'd16));
        push_beat(spike_beat(6'd32, 6'd0));
        push_beat(spike_beat(6'd0, 6'd32));
        push_beat(spike_beat(6'd47, 6'd31));
        push_beat(tick_beat());
        wait_idle();

        // Zero-length window behaves as one tick; core 0 over target at reset bias hits
        // the weak limit, core 3 lands on target, the rest are raised
        write_reg(srbr_pkg::CFG_WINDOW_TICKS, '0);
        write_reg(srbr_pkg::CFG_TARGET_COUNT, 25'd2);
        write_reg(srbr_pkg::CFG_ADJUST_ENABLE, 25'd1);
        repeat (3) push_beat(spike_beat(6'd5, 6'd9));
        repeat (2) push_beat(spike_beat(6'd20, 6'd27));
        push_beat(tick_beat());
        wait_idle();

        write_reg(srbr_pkg::CFG_WINDOW_TICKS, WINDOW_MAX);
        repeat (3) push_beat(tick_beat());
        wait_idle();

        // Window now shorter than the ticks already seen: next tick closes it
        write_reg(srbr_pkg::CFG_WINDOW_TICKS, 25'd2);
        write_reg(srbr_pkg::CFG_TARGET_COUNT, TARGET_MAX);
        push_beat(tick_beat());
        wait_idle();

        // Walk every core up to the strongest bias and past it
        write_reg(srbr_pkg::CFG_WINDOW_TICKS, 25'd1);
        repeat (150) push_beat(tick_beat());
        wait_idle();

        // Walk one core back down far enough to step coarse
        write_reg(srbr_pkg::CFG_TARGET_COUNT, '0);
        hot = 4'($urandom_range(0, 15));
        repeat (20)
        begin
            push_beat(core_spike(hot));
            push_beat(tick_beat());
        end
        wait_idle();

        while (beats_queued < ITEM_GOAL)
        begin
            pick = $urandom_range(0, 9);
            if ($urandom_range(0, 9) < 7)
                write_reg(srbr_pkg::CFG_WINDOW_TICKS,
                          (pick == 0) ? '0 : (pick == 1) ? 25'd1 :
                          (pick == 2) ? WINDOW_MAX :
                          srbr_pkg::CFG_DATA_W'($urandom_range(2, 8)));
            pick = $urandom_range(0, 7);
            if ($urandom_range(0, 9) < 7)
                write_reg(srbr_pkg::CFG_TARGET_COUNT,
                          (pick == 0) ? '0 : (pick == 1) ? TARGET_MAX :
                          (pick == 2) ? srbr_pkg::CFG_DATA_W'($urandom()) :
                          srbr_pkg::CFG_DATA_W'($urandom_range(0, 4)));
            if ($urandom_range(0, 9) < 7)
                write_reg(srbr_pkg::CFG_ADJUST_ENABLE,
                          srbr_pkg::CFG_DATA_W'($urandom_range(0, 3) != 0));
            hot = 4'($urandom_range(0, 15));
            n   = $urandom_range(20, 60);
            repeat (n)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_beat(tick_beat());
                else if ($urandom_range(0, 2) == 0)
                    push_beat(core_spike(hot));
                else
                    push_beat(spike_beat(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63))));
            end
            wait_idle();
        end

        if (errors == 0)
            $display("** spike_rate_bias_regulator: PASSED **");
        else
            $display("** spike_rate_bias_regulator: FAILED **");
        $finish;
    end

endmodule
